/* hw/rtl/bsfe_pkg.sv */
`default_nettype none
package bsfe_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int SLOT_LIMIT  = 2 * MAX_PAYLOAD;
    localparam int CNT_W       = $clog2(SLOT_LIMIT + 1);
    localparam int MAX_RES     = 9;
    localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W   = $clog2(MAX_RES);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_VALUE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_SEQ0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_SEQ1 = 3'd5;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] address;
        logic       frame_number;
        logic       empty_frame;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       dropped;
    } t_out_word;

    typedef struct packed {
        t_out_word [MAX_RES-1:0] ent;
        logic [RES_CNT_W-1:0]    count;
    } t_res_list;

endpackage
`default_nettype wire

/* hw/rtl/bsfe_builder.sv */
`default_nettype none
module bsfe_builder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bsfe_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                                i_accept,
    input  wire bsfe_pkg::t_in_word                  i_word,
    output bsfe_pkg::t_res_list                      o_list
);

    logic [7:0] r_flag, r_esc, r_flag_code, r_esc_code, r_seq0, r_seq1;
    logic [7:0] r_acc, n_acc;
    logic [bsfe_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0] r_ctl, n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= 8'd126;
            r_esc       <= 8'd125;
            r_flag_code <= 8'd94;
            r_esc_code  <= 8'd93;
            r_seq0      <= 8'd0;
            r_seq1      <= 8'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsfe_pkg::CFG_FLAG_VALUE:   r_flag      <= i_cfg_wdata;
                bsfe_pkg::CFG_ESCAPE_VALUE: r_esc       <= i_cfg_wdata;
                bsfe_pkg::CFG_FLAG_CODE:    r_flag_code <= i_cfg_wdata;
                bsfe_pkg::CFG_ESCAPE_CODE:  r_esc_code  <= i_cfg_wdata;
                bsfe_pkg::CFG_CONTROL_SEQ0: r_seq0      <= i_cfg_wdata;
                bsfe_pkg::CFG_CONTROL_SEQ1: r_seq1      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_ctl <= '0;
        end else if (i_accept) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_ctl <= n_ctl;
        end
    end

    logic [7:0] byte_q [bsfe_pkg::MAX_RES];
    logic       drop_q [bsfe_pkg::MAX_RES];
    logic [bsfe_pkg::RES_CNT_W-1:0] n_res;
    logic [7:0] ctl;
    logic       pb_pair;
    logic [bsfe_pkg::CNT_W:0] need_sum;

    always_comb begin
        for (int i = 0; i < bsfe_pkg::MAX_RES; i++) begin
            byte_q[i] = '0;
            drop_q[i] = 1'b0;
        end
        n_res    = '0;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_ctl    = r_ctl;
        ctl      = i_word.frame_number ? r_seq1 : r_seq0;
        pb_pair  = (i_word.payload_byte == r_flag) || (i_word.payload_byte == r_esc);
        need_sum = '0;

        if (i_word.empty_frame || i_word.first_byte) begin
            n_ctl = ctl;
            byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = r_flag;
            n_res = n_res + 1'b1;
            byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = i_word.address;
            n_res = n_res + 1'b1;
            byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = ctl;
            n_res = n_res + 1'b1;
            byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = i_word.address ^ ctl;
            n_res = n_res + 1'b1;
            n_acc = '0;
            n_cnt = '0;
        end

        if (!i_word.empty_frame) begin
            need_sum = {1'b0, n_cnt} + (pb_pair ? (bsfe_pkg::CNT_W+1)'(2)
                                                : (bsfe_pkg::CNT_W+1)'(1));
            if (need_sum <= (bsfe_pkg::CNT_W+1)'(bsfe_pkg::SLOT_LIMIT)) begin
                if (pb_pair) begin
                    byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = r_esc;
                    n_res = n_res + 1'b1;
                    byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] =
                        (i_word.payload_byte == r_flag) ? r_flag_code : r_esc_code;
                end else begin
                    byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = i_word.payload_byte;
                end
                n_res = n_res + 1'b1;
                n_cnt = need_sum[bsfe_pkg::CNT_W-1:0];
                n_acc = n_acc ^ i_word.payload_byte;
            end else begin
                drop_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = 1'b1;
                n_res = n_res + 1'b1;
            end
        end

        if (i_word.empty_frame || i_word.last_byte) begin
            if ((n_acc == r_flag) || (n_acc == r_esc)) begin
                byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = r_esc;
                n_res = n_res + 1'b1;
                byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] =
                    (n_acc == r_flag) ? r_flag_code : r_esc_code;
            end else begin
                byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = n_acc;
            end
            n_res = n_res + 1'b1;
            byte_q[n_res[bsfe_pkg::RES_IDX_W-1:0]] = r_flag;
            n_res = n_res + 1'b1;
            n_acc = '0;
            n_cnt = '0;
        end

        for (int i = 0; i < bsfe_pkg::MAX_RES; i++) begin
            o_list.ent[i].out_byte    = byte_q[i];
            o_list.ent[i].dropped     = drop_q[i];
            o_list.ent[i].last_of_run = (n_res == (bsfe_pkg::RES_CNT_W)'(i + 1));
        end
        o_list.count = n_res;
    end

endmodule
`default_nettype wire

/* hw/rtl/bsfe_serializer.sv */
`default_nettype none
module bsfe_serializer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bsfe_pkg::t_res_list  i_list,
    input  wire logic                 i_load,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output bsfe_pkg::t_out_word       o_data
);

    bsfe_pkg::t_out_word [bsfe_pkg::MAX_RES-1:0] r_buf, n_buf;
    logic [bsfe_pkg::RES_CNT_W-1:0] r_left;
    logic                           r_ovalid;
    bsfe_pkg::t_out_word            r_out;
    logic                           move;

    assign move    = (r_left != '0) && (!r_ovalid || i_ready);
    assign o_ready = (r_left == '0) || ((r_left == (bsfe_pkg::RES_CNT_W)'(1)) && move);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        for (int i = 0; i < bsfe_pkg::MAX_RES - 1; i++) begin
            n_buf[i] = r_buf[i+1];
        end
        n_buf[bsfe_pkg::MAX_RES-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                r_left <= i_list.count;
            end else if (move) begin
                r_left <= r_left - 1'b1;
            end
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_list.ent;
        end else if (move) begin
            r_buf <= n_buf;
        end
        if (move) begin
            r_out <= r_buf[0];
        end
    end

`ifndef SYNTHESIS
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= (bsfe_pkg::RES_CNT_W)'(bsfe_pkg::MAX_RES))
        else $error("result count out of range");

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_left == '0) || ((r_left == (bsfe_pkg::RES_CNT_W)'(1)) && move))
        else $error("list loaded over pending words");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_list.count != '0))
        else $error("accepted word produced no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_out)))
        else $error("stalled output word changed");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.dropped) |-> (r_out.out_byte == 8'd0))
        else $error("drop marker carries data");
`endif

endmodule
`default_nettype wire

/* hw/rtl/byte_stuffing_frame_encoder.sv */
`default_nettype none
// Byte-stuffing frame encoder: each accepted input word yields one to nine
// output words (header on first_byte or empty_frame, the stuffed payload byte
// or a drop marker, then the stuffed XOR check and closing flag on last_byte
// or empty_frame); last_of_run marks the final one. An input word is taken in
// the cycle it arrives when no results are pending, and the output register
// then sends one word per cycle unless i_out_ready stalls it, so a plain
// payload byte yields one output word and a stuffed one two. The next input
// word is accepted as the last result of the previous one moves to the output
// register. Configuration writes must be made while no results are pending.
module byte_stuffing_frame_encoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bsfe_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire bsfe_pkg::t_in_word                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output bsfe_pkg::t_out_word                      o_out_data
);

    bsfe_pkg::t_res_list list;
    logic                accept;

    assign accept = i_in_valid && o_in_ready;

    bsfe_builder u_builder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_word      (i_in_data),
        .o_list      (list)
    );

    bsfe_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_list  (list),
        .i_load  (accept),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* test/byte_stuffing_frame_encoder_tb.sv */
`timescale 1ns / 1ps
module byte_stuffing_frame_encoder_tb;
    import bsfe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [7:0] DEF_FLAG      = 8'h7E;
    localparam logic [7:0] DEF_ESCAPE    = 8'h7D;
    localparam logic [7:0] DEF_FLAG_CODE = 8'h5E;
    localparam logic [7:0] DEF_ESC_CODE  = 8'h5D;
    localparam logic [7:0] DEF_CTL_SEQ0  = 8'h00;
    localparam logic [7:0] DEF_CTL_SEQ1  = 8'h40;

    localparam int GAP_MAX         = 13;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_WORDS    = 170;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    t_in_word              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_word             out_data;

    byte_stuffing_frame_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Encoder state mirror
    logic [7:0] flag_val;
    logic [7:0] esc_val;
    logic [7:0] flag_code;
    logic [7:0] esc_code;
    logic [7:0] ctl_seq0;
    logic [7:0] ctl_seq1;
    logic [7:0] running_check;
    logic [7:0] frame_control;
    int         slots_used;

    t_out_word run_bytes[$];
    t_out_word expected_bytes[$];

    int errors       = 0;
    int words_sent   = 0;
    int src_gap_max  = GAP_MAX;
    int sink_gap_max = GAP_MAX;
    int hold_off_req = 0;
    int idle_cycles  = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void add_byte(input logic [7:0] b, input logic drop);
        t_out_word w;
        w.out_byte    = b;
        w.last_of_run = 1'b0;
        w.dropped     = drop;
        run_bytes.push_back(w);
    endfunction

    function automatic void add_stuffed(input logic [7:0] b);
        if (b == flag_val) begin
            add_byte(esc_val, 1'b0);
            add_byte(flag_code, 1'b0);
        end else if (b == esc_val) begin
            add_byte(esc_val, 1'b0);
            add_byte(esc_code, 1'b0);
        end else begin
            add_byte(b, 1'b0);
        end
    endfunction

    function automatic void add_header(input logic [7:0] addr, input logic fnum);
        frame_control = fnum ? ctl_seq1 : ctl_seq0;
        add_byte(flag_val, 1'b0);
        add_byte(addr, 1'b0);
        add_byte(frame_control, 1'b0);
        add_byte(addr ^ frame_control, 1'b0);
    endfunction

    function automatic void add_trailer();
        add_stuffed(running_check);
        add_byte(flag_val, 1'b0);
        running_check = 8'h00;
        slots_used    = 0;
    endfunction

    function automatic void encode_word(input t_in_word w);
        t_out_word tail;
        int        need;
        if (w.empty_frame) begin
            add_header(w.address, w.frame_number);
            running_check = 8'h00;
            slots_used    = 0;
            add_trailer();
        end else begin
            if (w.first_byte) begin
                add_header(w.address, w.frame_number);
                running_check = 8'h00;
                slots_used    = 0;
            end
            need = (w.payload_byte == flag_val || w.payload_byte == esc_val) ? 2 : 1;
            if (slots_used + need <= SLOT_LIMIT) begin
                add_stuffed(w.payload_byte);
                slots_used    = slots_used + need;
                running_check = running_check ^ w.payload_byte;
            end else begin
                add_byte(8'h00, 1'b1);
            end
            if (w.last_byte)
                add_trailer();
        end
        while (run_bytes.size() > 1)
            expected_bytes.push_back(run_bytes.pop_front());
        tail = run_bytes.pop_front();
        tail.last_of_run = 1'b1;
        expected_bytes.push_back(tail);
    endfunction

    function automatic t_in_word make_word(input logic [7:0] pb, input logic first,
                                           input logic last, input logic [7:0] addr,
                                           input logic fnum, input logic empty);
        t_in_word w;
        w.payload_byte = pb;
        w.first_byte   = first;
        w.last_byte    = last;
        w.address      = addr;
        w.frame_number = fnum;
        w.empty_frame  = empty;
        return w;
    endfunction

    // Biased toward bytes that need stuffing
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return flag_val;
            1: return esc_val;
            2: return flag_code;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [7:0] want,
                                            input logic [7:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data  = w;
        in_valid = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        encode_word(w);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            CFG_FLAG_VALUE:   flag_val  = val;
            CFG_ESCAPE_VALUE: esc_val   = val;
            CFG_FLAG_CODE:    flag_code = val;
            CFG_ESCAPE_CODE:  esc_code  = val;
            CFG_CONTROL_SEQ0: ctl_seq0  = val;
            CFG_CONTROL_SEQ1: ctl_seq1  = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_config(input logic [7:0] f, input logic [7:0] e, input logic [7:0] fc,
                               input logic [7:0] ec, input logic [7:0] c0,
                               input logic [7:0] c1);
        write_reg(CFG_FLAG_VALUE, f);
        write_reg(CFG_ESCAPE_VALUE, e);
        write_reg(CFG_FLAG_CODE, fc);
        write_reg(CFG_ESCAPE_CODE, ec);
        write_reg(CFG_CONTROL_SEQ0, c0);
        write_reg(CFG_CONTROL_SEQ1, c1);
    endtask

    task automatic test_directed_frames();
        // bytes before any opening extend the reset state
        send_word(make_word(8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h7E, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
        // empty frames; first, last and payload ignored
        send_word(make_word(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1));
        send_word(make_word(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
        send_word(make_word(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b0));
        send_word(make_word(8'h7D, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h7E, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h5E, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
        // one-byte frames where both payload and check need stuffing
        send_word(make_word(8'h7E, 1'b1, 1'b1, 8'hAA, 1'b1, 1'b0));
        send_word(make_word(8'h7D, 1'b1, 1'b1, 8'h55, 1'b0, 1'b0));
        // check byte lands on flag, then on escape
        send_word(make_word(8'h12, 1'b1, 1'b0, 8'h01, 1'b0, 1'b0));
        send_word(make_word(8'h6C, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0));
        send_word(make_word(8'h10, 1'b1, 1'b0, 8'h80, 1'b1, 1'b0));
        send_word(make_word(8'h6D, 1'b0, 1'b1, 8'h80, 1'b1, 1'b0));
        // reopen without closing
        send_word(make_word(8'h7E, 1'b1, 1'b0, 8'h33, 1'b0, 1'b0));
        send_word(make_word(8'h01, 1'b1, 1'b0, 8'hCC, 1'b1, 1'b0));
        send_word(make_word(8'h02, 1'b0, 1'b1, 8'hCC, 1'b1, 1'b0));
        send_word(make_word(8'hA5, 1'b0, 1'b0, 8'h81, 1'b1, 1'b1));
        drain();
    endtask

    task automatic test_config_registers();
        load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(make_word(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b1));
        drain();
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(make_word(8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b1, 1'b0, 8'hFF, 1'b1, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0));
        drain();
        load_config(8'h3A, 8'hC5, 8'h01, 8'hFE, 8'h13, 8'h8F);
        write_reg(CFG_SPARE_LO, 8'h3A);
        write_reg(CFG_SPARE_HI, 8'hC5);
        send_word(make_word(8'h3A, 1'b1, 1'b0, 8'h77, 1'b0, 1'b0));
        send_word(make_word(8'hC5, 1'b0, 1'b0, 8'h77, 1'b0, 1'b0));
        send_word(make_word(8'h7E, 1'b0, 1'b1, 8'h77, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0, 8'h5A, 1'b1, 1'b1));
        drain();
        load_config(DEF_FLAG, DEF_ESCAPE, DEF_FLAG_CODE, DEF_ESC_CODE, DEF_CTL_SEQ0,
                    DEF_CTL_SEQ1);
    endtask

    // Fill the frame to the slot limit with stuffed pairs, then probe the edge
    task automatic test_slot_limit();
        src_gap_max  = 2;
        sink_gap_max = 2;
        send_word(make_word(flag_val, 1'b1, 1'b0, 8'h3C, 1'b0, 1'b0));
        repeat (SLOT_LIMIT / 2 - 2)
            send_word(make_word(flag_val, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(flag_val, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        send_word(make_word(esc_val, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h04, 1'b1, 1'b1, 8'hC3, 1'b1, 1'b0));
        drain();
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    task automatic test_output_backpressure();
        logic [7:0] addr;
        src_gap_max  = 0;
        sink_gap_max = 0;
        hold_off_req = HOLD_OFF_CYCLES;
        addr = 8'($urandom_range(0, 255));
        for (int i = 0; i < 30; i++)
            send_word(make_word(pick_byte(), i % 6 == 0, i % 6 == 5, addr, 1'(i / 6), 1'b0));
        drain();
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    task automatic test_random_traffic();
        int         target;
        int         len;
        int         kind;
        logic [7:0] addr;
        logic       fnum;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            drain();
            if ($urandom_range(0, 2) != 0)
                load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                load_config(DEF_FLAG, DEF_ESCAPE, DEF_FLAG_CODE, DEF_ESC_CODE, DEF_CTL_SEQ0,
                            DEF_CTL_SEQ1);
            src_gap_max  = $urandom_range(0, 1) ? GAP_MAX : 0;
            sink_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
            repeat (5) begin
                kind = $urandom_range(0, 7);
                addr = 8'($urandom_range(0, 255));
                fnum = 1'($urandom_range(0, 1));
                if (kind == 0) begin
                    send_word(make_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)), addr, fnum, 1'b1));
                end else if (kind == 1) begin
                    send_word(make_word(pick_byte(), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)), addr, fnum, 1'b0));
                end else begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++)
                        send_word(make_word(pick_byte(), i == 0, i == len - 1, addr, fnum,
                                            1'b0));
                end
            end
        end
        drain();
    endtask

    // Output sink with per-word random stall and an optional long hold-off
    initial begin : sink
        int gap;
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, sink_gap_max);
            if (hold_off_req > 0) begin
                gap          = hold_off_req;
                hold_off_req = 0;
            end
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_word want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, actual %h", $time,
                             out_data);
            end else begin
                want = expected_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, out_data.out_byte);
                if (out_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 8'(want.last_of_run),
                                    8'(out_data.last_of_run));
                if (out_data.dropped !== want.dropped)
                    report_mismatch("dropped", 8'(want.dropped), 8'(out_data.dropped));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        flag_val      = DEF_FLAG;
        esc_val       = DEF_ESCAPE;
        flag_code     = DEF_FLAG_CODE;
        esc_code      = DEF_ESC_CODE;
        ctl_seq0      = DEF_CTL_SEQ0;
        ctl_seq1      = DEF_CTL_SEQ1;
        running_check = 8'h00;
        frame_control = 8'h00;
        slots_used    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_frames();
        test_config_registers();
        test_slot_limit();
        test_output_backpressure();
        test_random_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bsfe_pkg.sv
hw/rtl/bsfe_builder.sv
hw/rtl/bsfe_serializer.sv
hw/rtl/byte_stuffing_frame_encoder.sv
test/byte_stuffing_frame_encoder_tb.sv
